>>> sv/pidaw_pkg.sv
// Package for the angle-wrapping PID controller.
// Widths, build constants, register map, sequencer states and saturation helpers.
// No dependencies.
package pidaw_pkg;

    localparam int DATA_W  = 32;              // Q16.16 data path
    localparam int FRAC_W  = 16;
    localparam int GAIN_W  = 24;              // Q8.16 gains
    localparam int LIM_W   = 31;
    localparam int DIFF_W  = DATA_W + 1;      // target - measured, first difference
    localparam int WRAP_W  = DATA_W + 2;      // difference after the wrap step
    localparam int DD_W    = DATA_W + 3;      // second difference
    localparam int MUL_A_W = 42;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int TERM_W  = PROD_W - FRAC_W;
    localparam int SUM_W   = 48;
    localparam int ADDR_W  = 5;
    localparam int APB_W   = 32;

    // Build constants: error deadband in Q16.16, derivative filter weight in Q0.16
    localparam logic [DATA_W-1:0] ERR_DEADBAND = 32'd0;
    localparam logic [FRAC_W-1:0] DERIV_FILTER = 16'd0;

    localparam logic signed [MUL_B_W-1:0] FILT_KEEP =
        MUL_B_W'(65536 - int'(DERIV_FILTER));
    localparam logic signed [MUL_B_W-1:0] FILT_GAIN = MUL_B_W'(DERIV_FILTER);

    typedef struct packed {
        logic                     mode;
        logic [GAIN_W-1:0]        kp;
        logic [GAIN_W-1:0]        ki;
        logic [GAIN_W-1:0]        kd;
        logic [LIM_W-1:0]         max_out;
        logic [LIM_W-1:0]         i_limit;
        logic [LIM_W-1:0]         integral_band;
        logic [LIM_W-1:0]         wrap_period;
    } cfg_t;

    typedef enum logic [2:0] {
        REG_MODE          = 3'd0,
        REG_KP            = 3'd1,
        REG_KI            = 3'd2,
        REG_KD            = 3'd3,
        REG_MAX_OUT       = 3'd4,
        REG_I_LIMIT       = 3'd5,
        REG_INTEGRAL_BAND = 3'd6,
        REG_WRAP_PERIOD   = 3'd7
    } reg_idx_t;

    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_WRAP,
        S_SAT,
        S_MUL_I,
        S_MUL_P,
        S_MUL_D,
        S_FILT_A,
        S_FILT_B,
        S_DSAT,
        S_SUM,
        S_CLAMP,
        S_DONE
    } state_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
            return hi[DATA_W-1:0];
        else if (v < lo)
            return lo[DATA_W-1:0];
        else
            return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_sym(
        input logic signed [SUM_W-1:0] v,
        input logic [LIM_W-1:0]        lim
    );
        logic signed [SUM_W-1:0] pos;
        logic signed [SUM_W-1:0] neg;
        pos = signed'(SUM_W'(lim));
        neg = -pos;
        if (v > pos)
            return pos[DATA_W-1:0];
        else if (v < neg)
            return neg[DATA_W-1:0];
        else
            return v[DATA_W-1:0];
    endfunction

endpackage

>>> sv/pid_controller_angle_wrap.sv
// Top level of the angle-wrapping PID controller: stream ports, APB registers,
// output register. Depends on pidaw_pkg, pidaw_cfg, pidaw_core.
//
// Each input item (target, measured, command) yields one drive item. A control
// step runs wrap and saturate, then the single shared 42x25 multiplier computes
// the P, I and D products (plus the two derivative filter products in positional
// mode) one per cycle, then the sum and clamp steps; a clear item goes straight
// to the result. The block takes no new item while a step is in progress, but a
// finished drive value waits in the output register, so the next item can be
// accepted before it is taken. Registers are to be written only between items;
// the block itself does not enforce this.
module pid_controller_angle_wrap
    import pidaw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [63:0]       s_tdata,   // [31:0] measured, [63:32] target
    input  logic              s_tuser,   // [0] command: 0 step, 1 clear
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [31:0] drive
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    cfg_t                     cfg;
    logic                     res_valid;
    logic                     res_load;
    logic signed [DATA_W-1:0] res_drive;
    logic                     m_tvalid_reg;
    logic                     m_tvalid_next;
    logic [DATA_W-1:0]        m_tdata_reg;

    pidaw_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pidaw_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_command  (s_tuser),
        .in_measured (signed'(s_tdata[DATA_W-1:0])),
        .in_target   (signed'(s_tdata[2*DATA_W-1:DATA_W])),
        .res_valid   (res_valid),
        .res_ready   (res_load),
        .res_drive   (res_drive)
    );

    // output register takes a new item when empty or being emptied
    assign res_load = res_valid && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        if (res_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            m_tdata_reg <= res_drive;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> sv/pidaw_mul.sv
// Shared signed multiplier for the PID sequencer, product registered.
// Returns floor(a*b / 2^16). Depends on pidaw_pkg.
module pidaw_mul
    import pidaw_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [TERM_W-1:0]  term
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    // dropping the low bits of a two's complement value is a floor
    assign term = prod_reg[PROD_W-1:FRAC_W];

endmodule

>>> sv/pidaw_cfg.sv
// APB register file for the PID controller: gains, limits, mode, wrap period.
// Depends on pidaw_pkg.
module pidaw_cfg
    import pidaw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode          <= MODE_POSITIONAL;
            cfg_reg.kp            <= '0;
            cfg_reg.ki            <= '0;
            cfg_reg.kd            <= '0;
            cfg_reg.max_out       <= '1;
            cfg_reg.i_limit       <= '1;
            cfg_reg.integral_band <= '1;
            cfg_reg.wrap_period   <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MODE:          cfg_reg.mode          <= pwdata[0];
                REG_KP:            cfg_reg.kp            <= pwdata[GAIN_W-1:0];
                REG_KI:            cfg_reg.ki            <= pwdata[GAIN_W-1:0];
                REG_KD:            cfg_reg.kd            <= pwdata[GAIN_W-1:0];
                REG_MAX_OUT:       cfg_reg.max_out       <= pwdata[LIM_W-1:0];
                REG_I_LIMIT:       cfg_reg.i_limit       <= pwdata[LIM_W-1:0];
                REG_INTEGRAL_BAND: cfg_reg.integral_band <= pwdata[LIM_W-1:0];
                REG_WRAP_PERIOD:   cfg_reg.wrap_period   <= pwdata[LIM_W-1:0];
                default:           cfg_reg.mode          <= cfg_reg.mode;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MODE:          prdata = APB_W'(cfg_reg.mode);
            REG_KP:            prdata = APB_W'(cfg_reg.kp);
            REG_KI:            prdata = APB_W'(cfg_reg.ki);
            REG_KD:            prdata = APB_W'(cfg_reg.kd);
            REG_MAX_OUT:       prdata = APB_W'(cfg_reg.max_out);
            REG_I_LIMIT:       prdata = APB_W'(cfg_reg.i_limit);
            REG_INTEGRAL_BAND: prdata = APB_W'(cfg_reg.integral_band);
            REG_WRAP_PERIOD:   prdata = APB_W'(cfg_reg.wrap_period);
            default:           prdata = '0;
        endcase
    end

endmodule

>>> sv/pidaw_core.sv
// PID sequencer: error wrap/saturate, three products on one shared multiplier (five
// with the positional filter), sum, clamp, history. Depends on pidaw_pkg, pidaw_mul.
module pidaw_core
    import pidaw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     in_command,
    input  logic signed [DATA_W-1:0] in_measured,
    input  logic signed [DATA_W-1:0] in_target,
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic signed [DATA_W-1:0] res_drive
);

    state_t state_reg;
    state_t state_next;

    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [WRAP_W-1:0] wrap_reg;
    logic signed [WRAP_W-1:0] wrap_next;
    logic signed [DATA_W-1:0] e_reg;
    logic signed [DATA_W-1:0] e_next;
    logic signed [DIFF_W-1:0] de_reg;
    logic signed [DD_W-1:0]   dd_reg;
    logic                     over_band_reg;
    logic signed [SUM_W-1:0]  i_raw_reg;
    logic signed [DATA_W-1:0] i_reg;
    logic signed [SUM_W-1:0]  p_reg;
    logic signed [SUM_W-1:0]  df_reg;
    logic signed [DATA_W-1:0] d_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [DATA_W-1:0] res_reg;

    logic signed [DATA_W-1:0] prev_error_reg;
    logic signed [DATA_W-1:0] prev_prev_error_reg;
    logic signed [DATA_W-1:0] integral_term_reg;
    logic signed [DATA_W-1:0] output_accum_reg;
    logic signed [DATA_W-1:0] last_deriv_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [TERM_W-1:0]  term;
    logic signed [DATA_W-1:0]  e_sat;
    logic [DIFF_W-1:0]         sat_mag;
    logic [DIFF_W-1:0]         e_mag;
    logic signed [WRAP_W-1:0]  per;
    logic signed [WRAP_W-1:0]  half;
    logic signed [WRAP_W-1:0]  dx;

    pidaw_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .term (term)
    );

    // ---- next state ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = in_command ? S_CLEAR : S_WRAP;
            end
            S_CLEAR:  state_next = S_DONE;
            S_WRAP:   state_next = S_SAT;
            S_SAT:    state_next = S_MUL_I;
            S_MUL_I:  state_next = S_MUL_P;
            S_MUL_P:  state_next = S_MUL_D;
            S_MUL_D:  state_next = (cfg.mode == MODE_INCREMENTAL) ? S_DSAT : S_FILT_A;
            S_FILT_A: state_next = S_FILT_B;
            S_FILT_B: state_next = S_DSAT;
            S_DSAT:   state_next = S_SUM;
            S_SUM:    state_next = S_CLAMP;
            S_CLAMP:  state_next = S_DONE;
            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // ---- outputs: handshake and multiplier operands ----
    always_comb
    begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            S_IDLE:   in_ready = 1'b1;
            S_DONE:   res_valid = 1'b1;
            S_MUL_I:
            begin
                mul_a = MUL_A_W'(e_reg);
                mul_b = MUL_B_W'(signed'(cfg.ki));
            end
            S_MUL_P:
            begin
                mul_a = (cfg.mode == MODE_INCREMENTAL) ? MUL_A_W'(de_reg) : MUL_A_W'(e_reg);
                mul_b = MUL_B_W'(signed'(cfg.kp));
            end
            S_MUL_D:
            begin
                mul_a = (cfg.mode == MODE_INCREMENTAL) ? MUL_A_W'(dd_reg) : MUL_A_W'(de_reg);
                mul_b = MUL_B_W'(signed'(cfg.kd));
            end
            S_FILT_A:
            begin
                // raw D term straight back into the multiplier
                mul_a = MUL_A_W'(term);
                mul_b = FILT_KEEP;
            end
            S_FILT_B:
            begin
                mul_a = MUL_A_W'(last_deriv_reg);
                mul_b = FILT_GAIN;
            end
            default:  mul_a = '0;
        endcase
    end

    // ---- error conditioning ----
    always_comb
    begin
        per  = signed'(WRAP_W'(cfg.wrap_period));
        half = per >>> 1;
        dx   = WRAP_W'(diff_reg);
        if (cfg.wrap_period != '0 && dx > half)
            wrap_next = dx - per;
        else if (cfg.wrap_period != '0 && dx < -half)
            wrap_next = dx + per;
        else
            wrap_next = dx;

        e_sat   = sat32(SUM_W'(wrap_reg));
        sat_mag = e_sat[DATA_W-1] ? DIFF_W'(-DIFF_W'(e_sat)) : DIFF_W'(e_sat);
        e_next  = (sat_mag < DIFF_W'(ERR_DEADBAND)) ? '0 : e_sat;

        e_mag   = e_reg[DATA_W-1] ? DIFF_W'(-DIFF_W'(e_reg)) : DIFF_W'(e_reg);
    end

    // ---- data path and history ----
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:   diff_reg <= DIFF_W'(in_target) - DIFF_W'(in_measured);
            S_WRAP:   wrap_reg <= wrap_next;
            S_SAT:    e_reg <= e_next;
            S_MUL_I:
            begin
                de_reg        <= DIFF_W'(e_reg) - DIFF_W'(prev_error_reg);
                dd_reg        <= DD_W'(e_reg) - (DD_W'(prev_error_reg) <<< 1)
                                 + DD_W'(prev_prev_error_reg);
                over_band_reg <= e_mag > DIFF_W'(cfg.integral_band);
            end
            S_MUL_P:
            begin
                if (cfg.mode == MODE_INCREMENTAL)
                    i_raw_reg <= SUM_W'(term);
                else if (over_band_reg)
                    i_raw_reg <= '0;
                else
                    i_raw_reg <= SUM_W'(integral_term_reg) + SUM_W'(term);
            end
            S_MUL_D:
            begin
                p_reg <= SUM_W'(term);
                i_reg <= (cfg.mode == MODE_INCREMENTAL) ? sat32(i_raw_reg)
                                                        : clamp_sym(i_raw_reg, cfg.i_limit);
            end
            S_FILT_B: df_reg <= SUM_W'(term);
            S_DSAT:
            begin
                d_reg <= (cfg.mode == MODE_INCREMENTAL) ? sat32(SUM_W'(term))
                                                        : sat32(df_reg + SUM_W'(term));
            end
            S_SUM:
            begin
                sum_reg <= ((cfg.mode == MODE_INCREMENTAL) ? SUM_W'(output_accum_reg) : '0)
                           + p_reg + SUM_W'(i_reg) + SUM_W'(d_reg);
            end
            S_CLAMP:  res_reg <= clamp_sym(sum_reg, cfg.max_out);
            S_CLEAR:  res_reg <= '0;
            default:  res_reg <= res_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            prev_error_reg      <= '0;
            prev_prev_error_reg <= '0;
            integral_term_reg   <= '0;
            output_accum_reg    <= '0;
            last_deriv_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                prev_error_reg      <= '0;
                prev_prev_error_reg <= '0;
                integral_term_reg   <= '0;
                output_accum_reg    <= '0;
                last_deriv_reg      <= '0;
            end
            else if (state_reg == S_CLAMP)
            begin
                prev_error_reg      <= e_reg;
                prev_prev_error_reg <= prev_error_reg;
                integral_term_reg   <= i_reg;
                output_accum_reg    <= clamp_sym(sum_reg, cfg.max_out);
                last_deriv_reg      <= d_reg;
            end
        end
    end

    assign res_drive = res_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("core ready again right after accepting an item");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |=> prev_error_reg == '0 && prev_prev_error_reg == '0
            && integral_term_reg == '0 && output_accum_reg == '0
            && last_deriv_reg == '0 && res_reg == '0)
        else $error("clear left history or result nonzero");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_reg))
        else $error("result dropped or changed before hand-off");

    a_accum_matches: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && $past(state_reg) == S_CLAMP |-> res_reg == output_accum_reg)
        else $error("stored output differs from delivered drive");
`endif

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for pid_controller_angle_wrap: stream items in, drive items out,
// gains and limits set over APB. A built-in predictor tracks the controller history.
// Depends on pidaw_pkg and the RTL under sv/.
module tb_top
    import pidaw_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_STEP  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [31:0] ANGLE_360 = 32'h0168_0000;
    localparam logic [31:0] LIM_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] GAIN_MAX  = 32'h007F_FFFF;
    localparam logic [31:0] GAIN_MIN  = 32'h0080_0000;

    typedef struct {
        logic        cmd;
        logic [31:0] meas;
        logic [31:0] targ;
        bit          drain_first;   // hold off until every pending drive item has come back
    } ctl_item_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [63:0]       s_tdata = '0;    // [31:0] measured, [63:32] target
    logic              s_tuser = 1'b0;  // [0] command
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;    // [31:0] drive
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0]  pwdata;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    ctl_item_t   ctl_item_q[$];
    logic [31:0] drive_q[$];
    ctl_item_t   cur_item;
    bit          drv_busy;
    bit          item_taken;
    int          gap_left;
    int          burst_left;
    int          stall_left;
    int          stall_kind;
    logic [31:0] stall_pat;
    int          err_cnt;

    // predictor copy of the registers and the controller history
    cfg_t   ctl_cfg;
    longint err_d1, err_d2, integ, accum, deriv_d1;

    pid_controller_angle_wrap u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    function automatic longint sat_word(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clip(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic longint magn(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // one controller step; >>> on longint is a floor shift
    function automatic logic [31:0] pid_step(input ctl_item_t it);
        longint e, p, i, d, sum, half, per;
        longint kp, ki, kd, gam;
        kp  = {{40{ctl_cfg.kp[23]}}, ctl_cfg.kp};
        ki  = {{40{ctl_cfg.ki[23]}}, ctl_cfg.ki};
        kd  = {{40{ctl_cfg.kd[23]}}, ctl_cfg.kd};
        per = {33'd0, ctl_cfg.wrap_period};
        gam = {48'd0, DERIV_FILTER};
        if (it.cmd == CMD_CLEAR)
        begin
            err_d1 = 0; err_d2 = 0; integ = 0; accum = 0; deriv_d1 = 0;
            return 32'd0;
        end
        e = {{32{it.targ[31]}}, it.targ} - {{32{it.meas[31]}}, it.meas};
        if (per != 0)
        begin
            half = per >>> 1;
            if (e > half)
                e = e - per;
            else if (e < -half)
                e = e + per;
        end
        e = sat_word(e);
        if (magn(e) < {32'd0, ERR_DEADBAND})
            e = 0;
        if (ctl_cfg.mode == MODE_POSITIONAL)
        begin
            p = (kp * e) >>> 16;
            if (magn(e) > {33'd0, ctl_cfg.integral_band})
                i = 0;
            else
                i = integ + ((ki * e) >>> 16);
            i = clip(i, {33'd0, ctl_cfg.i_limit});
            d = (kd * (e - err_d1)) >>> 16;
            d = ((d * (65536 - gam)) >>> 16) + ((gam * deriv_d1) >>> 16);
            d = sat_word(d);
            sum = clip(p + i + d, {33'd0, ctl_cfg.max_out});
        end
        else
        begin
            p = (kp * (e - err_d1)) >>> 16;
            i = sat_word((ki * e) >>> 16);
            d = sat_word((kd * (e - 2 * err_d1 + err_d2)) >>> 16);
            sum = clip(accum + p + i + d, {33'd0, ctl_cfg.max_out});
        end
        integ    = i;
        deriv_d1 = d;
        accum    = sum;
        err_d2   = err_d1;
        err_d1   = e;
        return sum[31:0];
    endfunction

    task automatic report_err(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        err_cnt++;
        $display("MISMATCH @%0t: %s got %h want %h", $time, what, got, want);
    endtask

    task automatic set_reg(input reg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE:          ctl_cfg.mode          = val[0];
            REG_KP:            ctl_cfg.kp            = val[23:0];
            REG_KI:            ctl_cfg.ki            = val[23:0];
            REG_KD:            ctl_cfg.kd            = val[23:0];
            REG_MAX_OUT:       ctl_cfg.max_out       = val[30:0];
            REG_I_LIMIT:       ctl_cfg.i_limit       = val[30:0];
            REG_INTEGRAL_BAND: ctl_cfg.integral_band = val[30:0];
            REG_WRAP_PERIOD:   ctl_cfg.wrap_period   = val[30:0];
            default: ;
        endcase
    endtask

    task automatic send(input logic cmd, input logic [31:0] meas, input logic [31:0] targ);
        ctl_item_t it;
        it.cmd         = cmd;
        it.meas        = meas;
        it.targ        = targ;
        it.drain_first = 1'b0;
        ctl_item_q.push_back(it);
    endtask

    task automatic wait_idle();
        while (ctl_item_q.size() != 0 || drv_busy || drive_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_gain();
        logic [31:0] g;
        case ($urandom_range(0, 3))
            0: g = $urandom;
            1: g = $urandom_range(0, 32'h0000_1000);
            default: g = $urandom_range(0, 32'h0004_0000);
        endcase
        if ($urandom_range(0, 1))
            g = -g;
        return g;
    endfunction

    function automatic logic [31:0] rand_lim();
        case ($urandom_range(0, 4))
            0: return LIM_MAX;
            1: return 32'd0;
            2: return $urandom;
            default: return $urandom >> $urandom_range(6, 16);
        endcase
    endfunction

    // mostly a measurement tracking its setpoint, some full-range noise and clears
    function automatic ctl_item_t rand_item(input logic [30:0] per);
        ctl_item_t   it;
        int unsigned sel;
        int unsigned pw;
        logic [31:0] delta;
        sel = $urandom_range(0, 99);
        pw  = {1'b0, per};
        it.drain_first = ($urandom_range(0, 99) == 0);
        it.cmd  = (sel < 4) ? CMD_CLEAR : CMD_STEP;
        it.meas = $urandom;
        it.targ = $urandom;
        if (sel >= 25)
        begin
            if (sel < 50 && pw != 0)
            begin
                it.meas = $urandom_range(0, 2 * pw - 1);
                it.targ = $urandom_range(0, 2 * pw - 1);
            end
            else
            begin
                if ($urandom_range(0, 1))
                    it.meas = $signed($urandom) >>> $urandom_range(4, 31);
                delta = $urandom >> $urandom_range(8, 31);
                if ($urandom_range(0, 1))
                    delta = -delta;
                it.targ = it.meas + delta;
            end
        end
        return it;
    endfunction

    task automatic rand_setup(input int k);
        logic [31:0] mo, mi, bd, wp;
        mo = rand_lim();
        mi = rand_lim();
        bd = rand_lim();
        case ($urandom_range(0, 3))
            0: wp = ANGLE_360;
            1: wp = $urandom >> $urandom_range(1, 16);
            default: wp = 32'd0;
        endcase
        if (k == 0)
        begin
            mo = 32'd0; mi = LIM_MAX; bd = 32'd0; wp = LIM_MAX;
        end
        else if (k == 1)
        begin
            mo = LIM_MAX; mi = 32'd0; bd = LIM_MAX; wp = 32'd0;
        end
        set_reg(REG_MODE, (k % 2 == 0) ? 32'(MODE_INCREMENTAL) : 32'(MODE_POSITIONAL));
        set_reg(REG_KP, (k == 0) ? GAIN_MAX : rand_gain());
        set_reg(REG_KI, (k == 0) ? GAIN_MIN : rand_gain());
        set_reg(REG_KD, rand_gain());
        set_reg(REG_MAX_OUT, mo);
        set_reg(REG_I_LIMIT, mi);
        set_reg(REG_INTEGRAL_BAND, bd);
        set_reg(REG_WRAP_PERIOD, wp);
    endtask

    // sender: bursts of items with random gaps
    always @(negedge clk)
    begin : drv_blk
        ctl_item_t it;
        if (rst_n)
        begin
            if (item_taken)
            begin
                drv_busy   = 1'b0;
                item_taken = 1'b0;
            end
            if (!drv_busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (ctl_item_q.size() != 0 &&
                         !(ctl_item_q[0].drain_first && drive_q.size() != 0))
                begin
                    it       = ctl_item_q.pop_front();
                    cur_item = it;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {it.targ, it.meas};
                    s_tuser  <= it.cmd;
                    drv_busy = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 24)
                                                               : $urandom_range(0, 3);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: back-pressure pattern, drawn anew whenever its stall counter runs out
    always @(negedge clk)
    begin : rdy_blk
        if (stall_left == 0)
        begin
            stall_left = $urandom_range(16, 96);
            stall_kind = $urandom_range(0, 3);
            stall_pat  = $urandom;
        end
        stall_left--;
        case (stall_kind)
            0: m_tready <= 1'b1;
            1: m_tready <= stall_pat[stall_left % 32];
            2: m_tready <= stall_pat[stall_left % 32] & stall_pat[(stall_left + 7) % 32];
            default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // check drive items, then predict for any item accepted at this edge
    always @(posedge clk)
    begin : mon_blk
        logic [31:0] want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (drive_q.size() == 0)
                begin
                    report_err("unexpected drive item", m_tdata, 32'd0);
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (m_tdata !== want)
                        report_err("drive", m_tdata, want);
                end
            end
            if (s_tvalid && s_tready)
            begin
                drive_q.push_back(pid_step(cur_item));
                item_taken = 1'b1;
            end
        end
    end

    initial
    begin : stim_blk
        ctl_item_t it;
        int k, n;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        ctl_cfg = '{mode: MODE_POSITIONAL, kp: '0, ki: '0, kd: '0,
                    max_out: LIM_MAX[30:0], i_limit: LIM_MAX[30:0],
                    integral_band: LIM_MAX[30:0], wrap_period: '0};
        err_d1 = 0; err_d2 = 0; integ = 0; accum = 0; deriv_d1 = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // positional: overflowing errors, integral clamp, integral band, floor on negatives
        set_reg(REG_MODE, 32'(MODE_POSITIONAL));
        set_reg(REG_KP, 32'h0001_0000);
        set_reg(REG_KI, 32'h0000_4000);
        set_reg(REG_KD, 32'h0000_8000);
        set_reg(REG_MAX_OUT, LIM_MAX);
        set_reg(REG_I_LIMIT, 32'h0020_0000);
        set_reg(REG_INTEGRAL_BAND, 32'h00A0_0000);
        set_reg(REG_WRAP_PERIOD, 32'd0);
        send(CMD_STEP, 32'h0000_0000, 32'h0000_0000);
        send(CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF);
        send(CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
        send(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(CMD_STEP, 32'h0000_0000, 32'h0040_0000);
        send(CMD_STEP, 32'h0000_0000, 32'h0040_0000);
        send(CMD_STEP, 32'h0000_0000, 32'h0040_0000);
        send(CMD_STEP, 32'h0000_0000, 32'h00B0_0000);
        send(CMD_STEP, 32'h0040_0000, 32'h0000_0000);
        send(CMD_STEP, 32'hFFFF_FFFF, 32'h0000_0000);
        wait_idle();

        // wrap: beyond half either way, exactly at half, smallest and largest period
        set_reg(REG_WRAP_PERIOD, ANGLE_360);
        send(CMD_STEP, 32'h0000_0000, 32'h0100_0000);
        send(CMD_STEP, 32'h0100_0000, 32'h0000_0000);
        send(CMD_STEP, 32'h0000_0000, 32'h00B4_0000);
        send(CMD_STEP, 32'h0000_0000, 32'hFF4C_0000);
        wait_idle();
        set_reg(REG_WRAP_PERIOD, 32'd1);
        send(CMD_STEP, 32'h0000_0000, 32'h0000_0001);
        send(CMD_STEP, 32'h0000_0001, 32'h0000_0000);
        wait_idle();
        set_reg(REG_WRAP_PERIOD, LIM_MAX);
        send(CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF);
        send(CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
        wait_idle();

        // incremental with extreme gains and a tight output clamp
        set_reg(REG_MODE, 32'(MODE_INCREMENTAL));
        set_reg(REG_KP, GAIN_MIN);
        set_reg(REG_KI, GAIN_MAX);
        set_reg(REG_KD, GAIN_MAX);
        set_reg(REG_MAX_OUT, 32'h0064_0000);
        set_reg(REG_WRAP_PERIOD, 32'd0);
        send(CMD_CLEAR, 32'h0000_0000, 32'h0000_0000);
        send(CMD_STEP, 32'h0000_0000, 32'h0001_0000);
        send(CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF);
        send(CMD_STEP, 32'h0005_0000, 32'h0000_0000);
        send(CMD_STEP, 32'h1234_5678, 32'h1234_5678);
        send(CMD_CLEAR, 32'h0000_0000, 32'h0000_0000);
        send(CMD_STEP, 32'h0000_0000, 32'hFFFF_0000);
        wait_idle();

        for (k = 0; k < 9; k++)
        begin
            rand_setup(k);
            for (n = 0; n < 110; n++)
            begin
                it = rand_item(ctl_cfg.wrap_period);
                if (n == 0)
                    it.drain_first = 1'b1;
                ctl_item_q.push_back(it);
            end
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : watchdog_blk
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
